// ===== src/lpfs_pkg.sv =====
// Shared types and constants for the length-prefixed frame splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package lpfs_pkg;

  localparam int unsigned HDR_BYTES       = 4;
  localparam int unsigned MAXLEN_W        = 17;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 17'd65536;
  localparam int unsigned FRAME_LIMIT_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] HEARTBEAT_WORD  = 32'hffff_ffff;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LEN_BAD = 2'd1,
    ERR_LEN_BIG = 2'd2
  } err_e;

  // One queued command: n beats taken from the top bytes of data.
  typedef struct packed {
    logic [2:0]  n;     // beats to emit, 1..4
    logic [31:0] data;  // first beat in [31:24]
    logic        last;  // final beat closes a frame
    err_e        err;   // error report (single zero beat)
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/length_prefixed_frame_splitter_unit.sv =====
// Length-prefixed frame splitter: one stream byte per beat in, frame bytes out.
// Throughput: one input beat per cycle sustained while the queue has room; a header
//   completes as a burst of up to four output beats, absorbed by the command queue.
// Path: a beat goes through the command queue, then the back end's output register.
// Reset (rst_ni low, async): no header bytes held, no body pending, error cleared,
//   max_frame_len back to 65536, queue and output stage empty.
`default_nettype none

module length_prefixed_frame_splitter_unit #(
  parameter int unsigned FRAME_LIMIT = lpfs_pkg::FRAME_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH = lpfs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // max_frame_len register
  input  wire logic                          cfg_we_i,
  input  wire logic [lpfs_pkg::MAXLEN_W-1:0] cfg_wdata_i,
  // byte stream in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] stream_byte
  // frames out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] frame_byte
  output logic                               m_axis_tlast,  // frame_last
  output logic [1:0]                         m_axis_tuser   // [1:0] error_code
);
  import lpfs_pkg::*;

  // Front -> queue -> back. Each input beat yields at most one command;
  // a command expands to one to four output beats in the back end.
  cmd_t push_cmd, head_cmd;
  logic push_valid, push_ready, head_valid, head_pop;

  lpfs_front #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_valid_i(s_axis_tvalid),
    .byte_ready_o(s_axis_tready),
    .byte_i      (s_axis_tdata),
    .cmd_valid_o (push_valid),
    .cmd_o       (push_cmd),
    .cmd_ready_i (push_ready)
  );

  lpfs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_cmd),
    .push_ready_o(push_ready),
    .pop_valid_o (head_valid),
    .pop_data_o  (head_cmd),
    .pop_i       (head_pop)
  );

  // Back end has its own output register, so a stalled sink does not
  // stop the front from taking bytes until the queue fills.
  lpfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(head_valid),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (head_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_err_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== src/lpfs_front.sv =====
// Front end: collects header bytes, classifies headers, tracks body bytes.
// Pushes beat groups into the command queue. Depends on lpfs_pkg.
`default_nettype none

module lpfs_front #(
  parameter int unsigned FRAME_LIMIT = lpfs_pkg::FRAME_LIMIT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lpfs_pkg::MAXLEN_W-1:0] cfg_wdata_i,
  input  wire logic                          byte_valid_i,
  output logic                               byte_ready_o,
  input  wire logic [7:0]                    byte_i,
  output logic                               cmd_valid_o,
  output lpfs_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_ready_i
);
  import lpfs_pkg::*;

  // Largest length that can pass both checks, and the body counter it needs.
  localparam int unsigned LenMax = (1 << MAXLEN_W) - 1;
  localparam int unsigned LenCap = (FRAME_LIMIT < LenMax) ? FRAME_LIMIT : LenMax;
  localparam int unsigned BodyW  = ($clog2(LenCap - 3) > 0) ? $clog2(LenCap - 3) : 1;

  logic [MAXLEN_W-1:0] max_len_q;
  logic [31:0]         win_q, win_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [BodyW-1:0]    body_q, body_d;
  logic                stuck_q, stuck_d;

  logic        accept;
  logic [31:0] win_next;
  logic [2:0]  cnt_next;

  assign byte_ready_o = cmd_ready_i;
  assign accept       = byte_valid_i & cmd_ready_i;
  assign win_next     = {win_q[23:0], byte_i};
  assign cnt_next     = cnt_q + 3'd1;

  always_comb begin
    win_d       = win_q;
    cnt_d       = cnt_q;
    body_d      = body_q;
    stuck_d     = stuck_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{n: 3'd1, data: 32'd0, last: 1'b0, err: ERR_NONE};
    if (accept && !stuck_q) begin
      if (body_q != '0) begin
        body_d      = body_q - BodyW'(1);
        cmd_valid_o = 1'b1;
        cmd_o.data  = {byte_i, 24'd0};
        cmd_o.last  = (body_q == BodyW'(1));
      end else begin
        win_d = win_next;
        cnt_d = cnt_next;
        if (cnt_next == 3'(HDR_BYTES)) begin
          if (win_next == HEARTBEAT_WORD) begin
            win_d = '0;
            cnt_d = '0;
          end else if (win_next == 32'd0 || win_next[31]) begin
            stuck_d     = 1'b1;
            cmd_valid_o = 1'b1;
            cmd_o.err   = ERR_LEN_BAD;
          end else if (win_next > {15'd0, max_len_q} || win_next > 32'(FRAME_LIMIT)) begin
            stuck_d     = 1'b1;
            cmd_valid_o = 1'b1;
            cmd_o.err   = ERR_LEN_BIG;
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o.data  = win_next;
            if (win_next[31:2] == 30'd0) begin
              // short length: emit len bytes, the rest start the next header
              cmd_o.n    = {1'b0, win_next[1:0]};
              cmd_o.last = 1'b1;
              case (win_next[1:0])
                2'd1:    begin win_d = {8'd0, win_next[23:0]};  cnt_d = 3'd3; end
                2'd2:    begin win_d = {16'd0, win_next[15:0]}; cnt_d = 3'd2; end
                default: begin win_d = {24'd0, win_next[7:0]};  cnt_d = 3'd1; end
              endcase
            end else begin
              cmd_o.n    = 3'(HDR_BYTES);
              cmd_o.last = (win_next == 32'(HDR_BYTES));
              body_d     = BodyW'(win_next - 32'(HDR_BYTES));
              win_d      = '0;
              cnt_d      = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAXLEN_RESET;
      win_q     <= '0;
      cnt_q     <= '0;
      body_q    <= '0;
      stuck_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      win_q   <= win_d;
      cnt_q   <= cnt_d;
      body_q  <= body_d;
      stuck_q <= stuck_d;
    end
  end

  a_silent_when_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_q |-> !cmd_valid_o) else $error("push after sticky error");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(HDR_BYTES)) else $error("header count out of range");
  a_cmd_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (cmd_o.n != 3'd0 && cmd_o.n <= 3'(HDR_BYTES)))
    else $error("bad beat count in command");

endmodule

`default_nettype wire

// ===== src/lpfs_queue.sv =====
// Short command queue between front and back end.
// Depends on lpfs_pkg for the command type.
`default_nettype none

module lpfs_queue #(
  parameter int unsigned DEPTH = lpfs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  lpfs_pkg::cmd_t      push_data_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output lpfs_pkg::cmd_t      pop_data_o,
  input  wire logic           pop_i
);
  import lpfs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("queue count overrun");

endmodule

`default_nettype wire

// ===== src/lpfs_back.sv =====
// Back end: expands queued commands into output beats through a
// registered output stage. Depends on lpfs_pkg.
`default_nettype none

module lpfs_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  lpfs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic [1:0]     out_err_o
);
  import lpfs_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [1:0] err_q;
  logic [1:0] idx_q;
  logic       load, final_beat;
  logic [7:0] sel_byte;

  assign load       = cmd_valid_i & (!valid_q | out_ready_i);
  assign final_beat = ({1'b0, idx_q} == cmd_i.n - 3'd1);
  assign cmd_pop_o  = load & final_beat;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = cmd_i.data[31:24];
      2'd1:    sel_byte = cmd_i.data[23:16];
      2'd2:    sel_byte = cmd_i.data[15:8];
      default: sel_byte = cmd_i.data[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      last_q <= final_beat & cmd_i.last;
      err_q  <= cmd_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_beat ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

`default_nettype wire

// ===== verif/tb_length_prefixed_frame_splitter_unit.sv =====
// Self-checking bench for length_prefixed_frame_splitter_unit: byte stream in, frame beats out.
// A predictor built into the bench checks every output beat as it is accepted.
// Depends on lpfs_pkg and the unit under test only.
`default_nettype none

module tb_length_prefixed_frame_splitter_unit;
  import lpfs_pkg::*;

  // Wait after the last expected beat: queue and output register plus margin, since
  // header bytes may still be in flight with nothing expected from them.
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // How the run is closed out; the error is sticky, so only one per run.
  typedef enum {
    END_ZERO_LEN, END_NEG_LEN, END_OVER_MAX, END_SHORT2, END_SHORT3, END_ONE_THEN_BIG
  } end_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    err_e       err;
  } frame_beat_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [MAXLEN_W-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;

  idle_mode_e  idle_mode = IDLE_NONE;
  logic [7:0]  stream_q[$];          // bytes waiting to be driven
  frame_beat_t expected_beats[$];    // predicted output beats, oldest first
  int unsigned mismatches = 0;

  // Predictor state
  logic [31:0]         hdr_win   = '0;
  logic [2:0]          hdr_cnt   = '0;
  logic [16:0]         body_left = '0;
  logic                err_stuck = 1'b0;
  logic [MAXLEN_W-1:0] max_len   = MAXLEN_RESET;

  length_prefixed_frame_splitter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] stream_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] frame_byte
    .m_axis_tlast  (m_axis_tlast),   // frame_last
    .m_axis_tuser  (m_axis_tuser)    // [1:0] error_code
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_expected(logic [7:0] data, logic last, err_e err);
    frame_beat_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    expected_beats.push_back(b);
  endfunction

  // Advance the deframer by one stream byte and queue the beats it causes.
  function automatic void deframe_byte(logic [7:0] b);
    logic [31:0] len;
    int unsigned emit;
    int unsigned keep_bytes;
    if (err_stuck) return;  // silent until reset
    if (body_left != 0) begin
      body_left--;
      add_expected(b, body_left == 0, ERR_NONE);
      return;
    end
    hdr_win = {hdr_win[23:0], b};
    hdr_cnt++;
    if (hdr_cnt < HDR_BYTES) return;
    if (hdr_win == HEARTBEAT_WORD) begin
      hdr_win = '0;
      hdr_cnt = '0;
      return;
    end
    len = hdr_win;
    if (len == 0 || len[31]) begin
      err_stuck = 1'b1;
      add_expected(8'h00, 1'b0, ERR_LEN_BAD);
      return;
    end
    if (len > {15'd0, max_len} || len > FRAME_LIMIT_DEF) begin
      err_stuck = 1'b1;
      add_expected(8'h00, 1'b0, ERR_LEN_BIG);
      return;
    end
    emit = (len < HDR_BYTES) ? len : HDR_BYTES;
    for (int unsigned i = 0; i < emit; i++)
      add_expected(hdr_win[31 - 8*i -: 8], (i + 1 == emit) && (len <= HDR_BYTES), ERR_NONE);
    if (len >= HDR_BYTES) begin
      body_left = 17'(len - HDR_BYTES);
      hdr_win   = '0;
      hdr_cnt   = '0;
    end else begin
      // short frame: the unused header bytes open the next header
      keep_bytes = HDR_BYTES - len;
      hdr_win &= (32'd1 << (8 * keep_bytes)) - 32'd1;
      hdr_cnt  = 3'(keep_bytes);
    end
  endfunction

  // ---------------------------------------------------------------- handshakes

  function automatic logic sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 65;
      IDLE_BOTH: return $urandom_range(99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 65;
      IDLE_BOTH: return $urandom_range(99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  // Driver: predicts on each accepted beat, then loads the next byte (or a gap).
  always @(posedge clk_i) begin
    logic load;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        load = stream_q.size() != 0 && !sender_gap();
        if (load) s_axis_tdata <= stream_q.pop_front();
        s_axis_tvalid <= load;
      end
    end
  end

  // Monitor: drives backpressure and checks each accepted output beat.
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !receiver_stall();
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $error("output beat with nothing expected: frame_byte %02h frame_last %0b error_code %0d",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("frame_byte: expected %02h, got %02h", want.data, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tuser !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, m_axis_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [7:0] b);
    stream_q.push_back(b);
  endtask

  task automatic push_header(logic [31:0] len);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
  endtask

  task automatic push_body(int unsigned n);
    repeat (n) push_byte(8'($urandom_range(255)));
  endtask

  task automatic push_frame(int unsigned len);
    push_header(len);
    push_body(len - HDR_BYTES);
  endtask

  // Well-formed random traffic: mostly small frames, some larger (at the maximum
  // when it is 40 or less), heartbeats mixed in.
  task automatic push_random_frames(int unsigned budget);
    int unsigned start;
    int unsigned r;
    start = stream_q.size();
    while (stream_q.size() - start < budget) begin
      r = $urandom_range(99);
      if (r < 10)
        push_header(HEARTBEAT_WORD);
      else if (r < 26)
        push_frame((max_len <= 40) ? max_len : $urandom_range(25, 40));
      else
        push_frame($urandom_range(HDR_BYTES, (max_len < 24) ? max_len : 24));
    end
  endtask

  // Sample on the falling edge so the driver's queue and valid have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (stream_q.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_len(logic [MAXLEN_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len = value;
  endtask

  initial begin
    end_kind_e end_kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: heartbeat, header-only frame, byte extremes.
    write_max_len(MAXLEN_RESET);
    idle_mode = IDLE_NONE;
    push_header(HEARTBEAT_WORD);
    push_header(32'd4);
    push_header(32'd5);
    push_byte(8'hFF);
    push_header(32'd6);
    push_byte(8'h00);
    push_byte(8'hA5);
    push_header(HEARTBEAT_WORD);
    push_frame(7);
    wait_drained();

    // Sender mostly idle; midway it stops inside a header until all is out.
    write_max_len(MAXLEN_W'($urandom_range(256, 600)));
    idle_mode = IDLE_SEND;
    push_random_frames(8);
    push_byte(8'h00);
    push_byte(8'h00);
    wait_drained();
    push_byte(8'h00);
    push_byte(8'h08);
    push_body(4);
    push_random_frames(8);
    wait_drained();

    // Receiver mostly stalled; smallest whole-header maximum.
    write_max_len(17'd4);
    idle_mode = IDLE_RECV;
    push_random_frames(16);
    wait_drained();

    // Light idling on both sides, wide maximum.
    write_max_len(MAXLEN_W'($urandom_range(600, 65536)));
    idle_mode = IDLE_BOTH;
    push_random_frames(20);
    wait_drained();

    // Close with the one sticky error, then bytes that must be ignored.
    end_kind = end_kind_e'($urandom_range(END_ONE_THEN_BIG));
    idle_mode = idle_mode_e'($urandom_range(IDLE_BOTH));
    case (end_kind)
      END_ZERO_LEN: begin
        write_max_len(MAXLEN_W'($urandom_range(1, 65536)));
        push_header(32'd0);
      end
      END_NEG_LEN: begin
        write_max_len(MAXLEN_W'($urandom_range(1, 65536)));
        push_byte(8'($urandom_range(8'h80, 8'hFE)));
        push_body(3);
      end
      END_OVER_MAX: begin
        write_max_len(17'd1);
        push_header($urandom_range(2, 65536));
      end
      END_SHORT2: begin
        write_max_len(MAXLEN_W'($urandom_range(2, 65536)));
        push_header(32'd2);
        push_body(2);
      end
      END_SHORT3: begin
        write_max_len(MAXLEN_W'($urandom_range(3, 65536)));
        push_header(32'd3);
        push_body(3);
      end
      default: begin  // END_ONE_THEN_BIG
        write_max_len(17'd1);
        push_header(32'd1);
        push_body(1);
      end
    endcase
    push_header(32'd8);
    push_body(8);
    wait_drained();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #24_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
